/* design/fde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fde_pkg
// Shared widths, register indexes and reset values of the delay echo core.
// ----------------------------------------------------------------------------
package fde_pkg;

  localparam int SAMPLE_W = 8;   // audio sample and stored entry
  localparam int DEPTH_W  = 8;   // feedback_depth register
  localparam int DELAY_W  = 10;  // delay_length register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEEDBACK_DEPTH = 2'd0,
    CFG_DELAY_LENGTH   = 2'd1
  } cfg_reg_e;

  localparam logic [DEPTH_W-1:0] FEEDBACK_DEPTH_RST = 8'd0;
  localparam logic [DELAY_W-1:0] DELAY_LENGTH_RST   = 10'd60;

  localparam logic [SAMPLE_W-1:0] MIDPOINT = 8'd127;

endpackage : fde_pkg
`default_nettype wire

/* design/fde_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fde_store
// Delay sample memory: one registered read port, one write port.
// ----------------------------------------------------------------------------
module fde_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire                              clk_i,
  input  wire                              rd_en_i,
  input  wire  [AW-1:0]                    rd_addr_i,
  output logic [fde_pkg::SAMPLE_W-1:0]     rd_data_o,
  input  wire                              wr_en_i,
  input  wire  [AW-1:0]                    wr_addr_i,
  input  wire  [fde_pkg::SAMPLE_W-1:0]     wr_data_i
);

  logic [fde_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [fde_pkg::SAMPLE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read-before-write on a same-address collision; caller forwards
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule : fde_store
`default_nettype wire

/* design/fde_mix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fde_mix
// Feedback scale by depth/255, mix with the input sample, clamp, re-bias.
// ----------------------------------------------------------------------------
module fde_mix (
  input  wire  [fde_pkg::SAMPLE_W-1:0] stored_i,
  input  wire  [fde_pkg::SAMPLE_W-1:0] sample_i,
  input  wire  [fde_pkg::DEPTH_W-1:0]  depth_i,
  output logic [fde_pkg::SAMPLE_W-1:0] echo_o
);

  logic signed [8:0]  diff;
  logic        [7:0]  mag;
  logic        [15:0] prod;
  logic        [16:0] acc;
  logic        [7:0]  quo;
  logic signed [9:0]  fb;
  logic signed [9:0]  dry;
  logic signed [9:0]  mix;
  logic signed [9:0]  clamped;
  logic        [9:0]  biased;

  always_comb begin
    diff = $signed({1'b0, fde_pkg::MIDPOINT}) - $signed({1'b0, stored_i});
    mag  = diff[8] ? 8'(-diff) : diff[7:0];
    prod = 16'(mag) * 16'(depth_i);
    // exact floor(x/255) in quo for x below 65280
    acc  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    quo  = acc[15:8];
    fb   = diff[8] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    dry  = $signed({2'b00, fde_pkg::MIDPOINT}) - $signed({2'b00, sample_i});
    mix  = dry + fb;
    if (mix < -10'sd127) begin
      clamped = -10'sd127;
    end else if (mix > 10'sd127) begin
      clamped = 10'sd127;
    end else begin
      clamped = mix;
    end
    biased = 10'(clamped + 10'sd127);
    echo_o = biased[7:0];
  end

endmodule : fde_mix
`default_nettype wire

/* design/feedback_delay_echo_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted sample item waits in stage 1, where the store read returns
//   and the mix is formed, then moves into the output register that offers it.
// Throughput: one item per cycle unless the output stalls, set by the one read and
//   one write port of the delay memory; back-to-back same-entry hits are forwarded.
// Reset: position, fill count and handshakes clear at once, registers take their
//   reset values; memory is not cleared, entries at/above the fill count read zero.
// ----------------------------------------------------------------------------
// feedback_delay_echo_core
// Feedback comb echo: mixes each sample with the scaled sample stored at the
// current delay position, writes the clamped mix back and returns it.
// ----------------------------------------------------------------------------
module feedback_delay_echo_core #(
  parameter int STORE_DEPTH = 512
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // sample in, tdata: [7:0] sample_in
  input  wire                               s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire  [7:0]                        s_axis_tdata_i,
  // echo out, tdata: [7:0] echo_out
  output logic                              m_axis_tvalid_o,
  input  wire                               m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,
  // register writes: index 0 feedback_depth, index 1 delay_length
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [fde_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [fde_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam int LW = (AW + 1 > fde_pkg::DELAY_W) ? AW + 1 : fde_pkg::DELAY_W;

  // config registers
  logic [fde_pkg::DEPTH_W-1:0] depth_q;
  logic [fde_pkg::DELAY_W-1:0] delay_q;

  // position and fill count (entries below fill_q have been written)
  logic [AW-1:0] pos_q, pos_d;
  logic [FW-1:0] fill_q, fill_d;

  // stage 1: read data back, mix computed
  logic                          s1_valid_q;
  logic [AW-1:0]                 s1_addr_q;
  logic [fde_pkg::SAMPLE_W-1:0]  s1_sample_q;
  logic                          s1_hit_q;
  logic                          s1_fwd_q;
  logic [fde_pkg::SAMPLE_W-1:0]  s1_fwd_data_q;

  // output register
  logic                          out_valid_q;
  logic [fde_pkg::SAMPLE_W-1:0]  out_echo_q;

  logic                          in_acc;
  logic                          s1_adv;
  logic [AW:0]                   pos_inc;
  logic                          wrap;
  logic [fde_pkg::SAMPLE_W-1:0]  rd_data;
  logic [fde_pkg::SAMPLE_W-1:0]  stored;
  logic [fde_pkg::SAMPLE_W-1:0]  echo;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= fde_pkg::FEEDBACK_DEPTH_RST;
      delay_q <= fde_pkg::DELAY_LENGTH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fde_pkg::CFG_FEEDBACK_DEPTH: depth_q <= cfg_data_i[fde_pkg::DEPTH_W-1:0];
        fde_pkg::CFG_DELAY_LENGTH:   delay_q <= cfg_data_i[fde_pkg::DELAY_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // stage 1 moves into the output register when it is free or being drained
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // position advance: wrap at delay_length or at the store end
  always_comb begin
    pos_inc = {1'b0, pos_q} + {{AW{1'b0}}, 1'b1};
    wrap    = (LW'(pos_inc) == LW'(delay_q)) || (pos_inc >= (AW+1)'(STORE_DEPTH));
    pos_d   = wrap ? '0 : pos_inc[AW-1:0];
    fill_d  = fill_q;
    if (FW'(pos_q) == fill_q) begin
      fill_d = FW'(fill_q + FW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fill_q <= '0;
    end else if (in_acc) begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // forward when the item leaving stage 1 writes the entry just read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q     <= pos_q;
      s1_sample_q   <= s_axis_tdata_i;
      s1_hit_q      <= FW'(pos_q) < fill_q;
      s1_fwd_q      <= s1_adv && (s1_addr_q == pos_q);
      s1_fwd_data_q <= echo;
    end
  end

  fde_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (pos_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (echo)
  );

  always_comb begin
    if (s1_fwd_q) begin
      stored = s1_fwd_data_q;
    end else if (s1_hit_q) begin
      stored = rd_data;
    end else begin
      stored = '0;  // never-written entry: reset value
    end
  end

  fde_mix u_mix (
    .stored_i (stored),
    .sample_i (s1_sample_q),
    .depth_i  (depth_q),
    .echo_o   (echo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_echo_q <= echo;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_echo_q;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(pos_q) < FW'(STORE_DEPTH))
    else $error("position beyond store depth");

  a_pos_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(pos_q) <= fill_q)
    else $error("position ahead of fill count");

  a_acc_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted item lost before stage 1");

  a_echo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_echo_q != 8'hFF))
    else $error("echo out of clamp range");
`endif

endmodule : feedback_delay_echo_core
`default_nettype wire

/* sim/feedback_delay_echo_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_delay_echo_core_tb
// Self-checking bench for the feedback comb echo core. Samples are streamed in
// from a queue, a behavioral copy of the delay store predicts each echo, and
// every echo item is compared against the oldest prediction. Register writes
// happen only while the core is drained; both stream sides stall at random.
// ----------------------------------------------------------------------------
module feedback_delay_echo_core_tb;
  import fde_pkg::*;

  localparam int STORE_DEPTH = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 38;
  localparam int DRAIN_WAIT  = 4;      // extra wait once every expected echo is seen

  // indexes with no register behind them, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid    = 1'b0;
  logic [SAMPLE_W-1:0]  in_data     = '0;
  logic                 out_ready   = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_DAT_W-1:0] cfg_data    = '0;
  wire                  in_ready;
  wire                  out_valid;
  wire  [SAMPLE_W-1:0]  out_data;
  wire                  cfg_ready;

  feedback_delay_echo_core #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // behavioral copy of the core state and registers
  logic [SAMPLE_W-1:0] echo_mem [STORE_DEPTH];
  logic [8:0]          echo_pos;
  logic [DEPTH_W-1:0]  fb_depth;
  logic [DELAY_W-1:0]  delay_len;

  logic [SAMPLE_W-1:0] sample_q [$];   // samples waiting for the driver
  logic [SAMPLE_W-1:0] echo_q   [$];   // predicted echoes, oldest first

  int idle_pct     = IDLE_PCT;
  int err_cnt      = 0;
  int sample_cnt   = 0;
  int echo_cnt     = 0;
  int cfg_cnt      = 0;
  int cycle_cnt    = 0;
  logic [SAMPLE_W-1:0] want_echo;

  // mix one sample with the stored entry, write it back, advance the position
  function automatic logic [SAMPLE_W-1:0] mix_and_store(input logic [SAMPLE_W-1:0] smp);
    int diff, mag, fb, mix, nxt;
    diff = int'(MIDPOINT) - int'(echo_mem[echo_pos]);
    mag  = (diff < 0) ? -diff : diff;
    mag  = (mag * int'(fb_depth)) / 255;
    fb   = (diff < 0) ? -mag : mag;
    mix  = (int'(MIDPOINT) - int'(smp)) + fb;
    if (mix < -127) mix = -127;
    if (mix > 127)  mix = 127;
    echo_mem[echo_pos] = SAMPLE_W'(mix + int'(MIDPOINT));
    nxt = int'(echo_pos) + 1;
    if (nxt == int'(delay_len) || nxt >= STORE_DEPTH) nxt = 0;
    echo_pos = 9'(nxt);
    return SAMPLE_W'(mix + int'(MIDPOINT));
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sample driver: on accept, predict; then offer the next queued sample
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        echo_q.push_back(mix_and_store(in_data));
        sample_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // echo monitor with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready <= ($urandom_range(99) >= idle_pct);
      if (out_valid && out_ready) begin
        echo_cnt++;
        if (echo_q.size() == 0) begin
          err_cnt++;
          $display("%0t ns: echo_out with nothing expected, expected none, actual %0d",
                   $time, out_data);
        end else begin
          want_echo = echo_q.pop_front();
          if (out_data !== want_echo) begin
            err_cnt++;
            $display("%0t ns: echo_out mismatch, expected %0d, actual %0d",
                     $time, want_echo, out_data);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d echoes still pending", cycle_cnt, echo_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // one register write; the shadow copy is updated at the accepting edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_cnt++;
    case (idx)
      CFG_FEEDBACK_DEPTH: fb_depth  = val[DEPTH_W-1:0];
      CFG_DELAY_LENGTH:   delay_len = val[DELAY_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // block until the core has nothing in flight
  task automatic wait_drained();
    do @(negedge clk_i); while (sample_q.size() != 0 || in_valid || echo_q.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  // random samples, with the rails and the midpoint drawn more often
  task automatic queue_random(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(15);
      if (pick == 0)      sample_q.push_back(8'd0);
      else if (pick == 1) sample_q.push_back(8'd255);
      else if (pick == 2) sample_q.push_back(MIDPOINT);
      else                sample_q.push_back(SAMPLE_W'($urandom_range(255)));
    end
  endtask

  initial begin
    foreach (echo_mem[i]) echo_mem[i] = '0;
    echo_pos  = '0;
    fb_depth  = FEEDBACK_DEPTH_RST;
    delay_len = DELAY_LENGTH_RST;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: no feedback, rails and midpoint neighbors
    sample_q.push_back(8'd0);   sample_q.push_back(8'd255); sample_q.push_back(8'd127);
    sample_q.push_back(8'd128); sample_q.push_back(8'd126); sample_q.push_back(8'd1);
    sample_q.push_back(8'd254); sample_q.push_back(8'd0);   sample_q.push_back(8'd255);
    sample_q.push_back(8'd127);
    wait_drained();

    // full feedback, delay length 1 set while the position is past it, so each sample meets
    // an unwritten entry; upper data bits must be masked off and spare indexes ignored
    write_reg(CFG_FEEDBACK_DEPTH, 10'h3FF);
    write_reg(CFG_DELAY_LENGTH, 10'd1);
    write_reg(CFG_SPARE_2, 10'h155);
    write_reg(CFG_SPARE_3, 10'h2AA);
    sample_q.push_back(8'd0);   sample_q.push_back(8'd0);   sample_q.push_back(8'd0);
    sample_q.push_back(8'd255); sample_q.push_back(8'd255); sample_q.push_back(8'd127);
    sample_q.push_back(8'd0);   sample_q.push_back(8'd255);
    wait_drained();

    write_reg(CFG_FEEDBACK_DEPTH, 10'd128);
    write_reg(CFG_DELAY_LENGTH, 10'd2);
    sample_q.push_back(8'd255); sample_q.push_back(8'd0);   sample_q.push_back(8'd255);
    sample_q.push_back(8'd0);   sample_q.push_back(8'd64);
    wait_drained();

    // zero delay length: wraps only at the end of the store; the sender is
    // held midway until every echo is back
    write_reg(CFG_FEEDBACK_DEPTH, CFG_DAT_W'($urandom_range(255)));
    write_reg(CFG_DELAY_LENGTH, 10'd0);
    queue_random(150);
    wait_drained();
    queue_random(150);
    wait_drained();

    // length shrunk below the position: runs on to the store end, then loops at 10;
    // no stalls on either side for this stretch
    idle_pct = 0;
    write_reg(CFG_FEEDBACK_DEPTH, 10'd255);
    write_reg(CFG_DELAY_LENGTH, 10'd10);
    queue_random(230);
    wait_drained();
    idle_pct = IDLE_PCT;

    // length past the store depth, then exactly the store depth
    write_reg(CFG_FEEDBACK_DEPTH, 10'd0);
    write_reg(CFG_DELAY_LENGTH, 10'h3FF);
    queue_random(60);
    wait_drained();
    write_reg(CFG_FEEDBACK_DEPTH, 10'd255);
    write_reg(CFG_DELAY_LENGTH, 10'd512);
    queue_random(60);
    wait_drained();

    // short random loops at random gains
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_FEEDBACK_DEPTH, CFG_DAT_W'($urandom_range(255)));
      write_reg(CFG_DELAY_LENGTH, CFG_DAT_W'($urandom_range(16, 1)));
      queue_random(25);
      wait_drained();
    end

    $display("covered %0d samples and %0d echoes over %0d register writes,",
             sample_cnt, echo_cnt, cfg_cnt);
    $display("including zero, oversize, store-depth and shrunk delay lengths");
    if (err_cnt == 0 && echo_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d echoes never seen", err_cnt, echo_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
